/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the debouncer checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising edge of clk, switched off while in reset.
`define AST_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion sampled on the rising edge of clk, also checked during reset.
`define AST_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/bdlp_pkg.sv */
// ---------------------------------------------------------------------------
// bdlp_pkg
// Types and constants shared by the button debouncer modules.
// ---------------------------------------------------------------------------
package bdlp_pkg;

  // Field widths fixed by the interface.
  localparam int TIME_W     = 32;
  localparam int RAW_W      = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_WINDOW      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_THRESHOLD = 4'd1;

  // Configuration reset values.
  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET   = 16'd40;
  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RESET = 16'd600;

  // Current configuration as seen by every lane.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] debounce_window;
    logic [CFG_DATA_W-1:0] long_press_threshold;
  } cfg_t;

  // What one lane reports for the current transaction.
  typedef struct packed {
    logic level;      // raw level of this tick
    logic evt;        // debounced release accepted
    logic evt_long;   // that release was a long press
  } lane_res_t;

  // One result transaction.
  typedef struct packed {
    logic [RAW_W-1:0] event_valid;
    logic [RAW_W-1:0] event_long;
    logic             wake_request;
  } result_t;

endpackage

/* design/bdlp_lane.sv */
// ---------------------------------------------------------------------------
// bdlp_lane
// Debounce and press-length classification for a single button.
// ---------------------------------------------------------------------------
module bdlp_lane (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            upd,
  input  logic [bdlp_pkg::TIME_W-1:0]     now_ms,
  input  logic                            lvl,
  input  bdlp_pkg::cfg_t                  cfg,
  output bdlp_pkg::lane_res_t             res
);

  logic                        last_raw_r, last_raw_nxt;
  logic                        deb_r, deb_nxt;
  logic [bdlp_pkg::TIME_W-1:0] chg_time_r, chg_time_nxt;
  logic [bdlp_pkg::TIME_W-1:0] start_time_r, start_time_nxt;

  logic                        changed;
  logic [bdlp_pkg::TIME_W-1:0] stable_for;
  logic [bdlp_pkg::TIME_W-1:0] held_for;
  logic                        stable;
  logic                        take;

  // A raw change restarts the stability timer from this tick.
  assign changed      = (lvl != last_raw_r);
  assign last_raw_nxt = lvl;
  assign chg_time_nxt = changed ? now_ms : chg_time_r;

  // Time differences wrap modulo 2^32.
  assign stable_for = now_ms - chg_time_nxt;
  assign held_for   = now_ms - start_time_r;
  assign stable     = (stable_for >= {{(bdlp_pkg::TIME_W-bdlp_pkg::CFG_DATA_W){1'b0}},
                                      cfg.debounce_window});
  assign take       = stable && (lvl != deb_r);

  // An accepted press records its start; an accepted release reports.
  assign deb_nxt        = take ? lvl : deb_r;
  assign start_time_nxt = (take && lvl) ? now_ms : start_time_r;

  assign res.level    = lvl;
  assign res.evt      = take && !lvl;
  assign res.evt_long = take && !lvl &&
                        (held_for >= {{(bdlp_pkg::TIME_W-bdlp_pkg::CFG_DATA_W){1'b0}},
                                      cfg.long_press_threshold});

  // Per-button state, updated once for each accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r   <= 1'b0;
      deb_r        <= 1'b0;
      chg_time_r   <= '0;
      start_time_r <= '0;
    end else if (upd) begin
      last_raw_r   <= last_raw_nxt;
      deb_r        <= deb_nxt;
      chg_time_r   <= chg_time_nxt;
      start_time_r <= start_time_nxt;
    end
  end

endmodule

/* design/bdlp_merge.sv */
// ---------------------------------------------------------------------------
// bdlp_merge
// Combines the lane reports into one result transaction.
// ---------------------------------------------------------------------------
module bdlp_merge #(
  parameter int NUM_BUTTONS = 4
) (
  input  bdlp_pkg::lane_res_t [NUM_BUTTONS-1:0] lane_res,
  output bdlp_pkg::result_t                     result
);

  logic [bdlp_pkg::RAW_W-1:0] ev_valid;
  logic [bdlp_pkg::RAW_W-1:0] ev_long;
  logic                       wake;

  // Only the buttons that have an output bit report events.
  for (genvar b = 0; b < bdlp_pkg::RAW_W; b++) begin : g_bit
    if (b < NUM_BUTTONS) begin : g_used
      assign ev_valid[b] = lane_res[b].evt;
      assign ev_long[b]  = lane_res[b].evt_long;
    end else begin : g_unused
      assign ev_valid[b] = 1'b0;
      assign ev_long[b]  = 1'b0;
    end
  end

  // Wake is raised when any button is pressed on this tick.
  always_comb begin
    wake = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      wake = wake | lane_res[i].level;
    end
  end

  assign result.event_valid  = ev_valid;
  assign result.event_long   = ev_long;
  assign result.wake_request = wake;

endmodule

/* design/bdlp_out_fifo.sv */
// ---------------------------------------------------------------------------
// bdlp_out_fifo
// Two-entry result buffer that decouples the input and result channels.
// ---------------------------------------------------------------------------
module bdlp_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bdlp_pkg::result_t push_data,
  output logic              not_full,
  output logic              pop_valid,
  input  logic              pop_ready,
  output bdlp_pkg::result_t pop_data
);

  bdlp_pkg::result_t mem_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  logic              pop;

  assign not_full  = (count_r != 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];

  // Pointer and fill-count bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Result storage carries no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* design/button_debounce_long_press.sv */
// ---------------------------------------------------------------------------
// button_debounce_long_press
// Debounces a set of buttons and classifies each release as short or long.
// ---------------------------------------------------------------------------
// Each input transaction is one update tick carrying a millisecond timestamp
// and the raw button levels; it yields exactly one result transaction, held
// in the result buffer, with the release events and the wake request. One
// tick is accepted every cycle while the result buffer has room: every
// button has its own lane that updates its state on each accepted tick, and
// a two-entry result buffer lets ticks keep flowing while a result waits.
// The input stalls only when that buffer is full. Configuration writes
// complete at once and are to be made while no tick is in flight.
module button_debounce_long_press #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Update ticks
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bdlp_pkg::TIME_W-1:0]        in_now_ms,
  input  logic [bdlp_pkg::RAW_W-1:0]         in_raw_levels,
  // Results
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bdlp_pkg::RAW_W-1:0]         out_event_valid,
  output logic [bdlp_pkg::RAW_W-1:0]         out_event_long,
  output logic                               out_wake_request,
  // Configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  bdlp_pkg::cfg_t                        cfg_r, cfg_nxt;
  bdlp_pkg::lane_res_t [NUM_BUTTONS-1:0] lane_res;
  bdlp_pkg::result_t                     result;
  bdlp_pkg::result_t                     out_data;
  logic                                  in_acc;
  logic                                  fifo_not_full;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        bdlp_pkg::REG_DEBOUNCE_WINDOW:      cfg_nxt.debounce_window      = cfg_data;
        bdlp_pkg::REG_LONG_PRESS_THRESHOLD: cfg_nxt.long_press_threshold = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_window      <= bdlp_pkg::DEBOUNCE_RESET;
      cfg_r.long_press_threshold <= bdlp_pkg::LONG_PRESS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // A tick is taken whenever the result buffer has room.
  assign in_ready = fifo_not_full;
  assign in_acc   = in_valid && in_ready;

  // One lane per button; buttons without a raw input bit read as released.
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    logic lvl;
    if (i < bdlp_pkg::RAW_W) begin : g_raw
      assign lvl = in_raw_levels[i];
    end else begin : g_none
      assign lvl = 1'b0;
    end

    bdlp_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .upd    (in_acc),
      .now_ms (in_now_ms),
      .lvl    (lvl),
      .cfg    (cfg_r),
      .res    (lane_res[i])
    );
  end

  bdlp_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .lane_res (lane_res),
    .result   (result)
  );

  bdlp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (result),
    .not_full  (fifo_not_full),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (out_data)
  );

  assign out_event_valid  = out_data.event_valid;
  assign out_event_long   = out_data.event_long;
  assign out_wake_request = out_data.wake_request;

endmodule

/* design/bdlp_checker.sv */
// ---------------------------------------------------------------------------
// bdlp_checker
// Port-level checks on the button debouncer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bdlp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [bdlp_pkg::RAW_W-1:0]      out_event_valid,
  input logic [bdlp_pkg::RAW_W-1:0]      out_event_long,
  input logic                            cfg_ready
);

  // A long-press flag only ever accompanies a release event.
  `AST_CLK(a_long_needs_event, out_valid |-> ((out_event_long & ~out_event_valid) == '0), "event_long set without event_valid")

  // Every accepted tick leaves a result waiting in the next cycle.
  `AST_CLK(a_tick_gives_result, (in_valid && in_ready) |=> out_valid, "accepted tick produced no result")

  // A waiting result is not withdrawn before it is taken.
  `AST_CLK(a_out_held, (out_valid && !out_ready) |=> out_valid, "result withdrawn before transaction")

  // Configuration writes are never stalled.
  `AST_CLK_ALWAYS(a_cfg_ready, cfg_ready, "configuration port not ready")

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (.*);
